// ----- src/adm_pkg.sv -----
package adm_pkg;

  // Q16 unity and output limit
  localparam int unsigned Q16_ONE     = 65536;
  localparam int unsigned POWER_LIMIT = 10000;

  // curve: fraction bits of the exponent product, integer shift at which the result is forced to zero
  localparam int unsigned EXP_STEPS    = 16;
  localparam int unsigned EXP_IP_LIMIT = 31;

  typedef enum logic [1:0] {
    CFG_REVERSE   = 2'd0,
    CFG_DEAD_ZONE = 2'd1,
    CFG_CURVE     = 2'd2
  } cfg_idx_e;

  typedef logic [EXP_STEPS-1:0][29:0] exp_fac_t;

  // integer square root, elaboration use only
  function automatic logic [63:0] isqrt_c(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bit_v;
    n     = n_in;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bit_v) begin
        n   = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^-(2^-(j+1)) in Q0.30, entry 0 for bit weight 1/2
  function automatic exp_fac_t exp_factors();
    exp_fac_t f;
    logic [63:0] v;
    v = isqrt_c(64'd1 << 59);
    for (int j = 0; j < EXP_STEPS; j++) begin
      f[j] = v[29:0];
      v    = isqrt_c(v << 30);
    end
    return f;
  endfunction

  localparam exp_fac_t EXP_FACTOR = exp_factors();

endpackage

// ----- src/adm_sqrt.sv -----
module adm_sqrt #(
  parameter int unsigned IN_W  = 48,
  parameter int unsigned TAG_W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [IN_W-1:0]    rad_i,
  input  logic [TAG_W-1:0]   tag_i,
  output logic               valid_o,
  output logic [IN_W/2-1:0]  root_o,
  output logic [TAG_W-1:0]   tag_o
);
  localparam int unsigned ROOT_W = IN_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;

  logic              vld_q  [ROOT_W];
  logic [IN_W-1:0]   rad_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [TAG_W-1:0]  tag_q  [ROOT_W];

  // one root bit per stage, two radicand bits consumed
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              vld_in;
    logic [IN_W-1:0]   rad_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    logic [TAG_W-1:0]  tag_in;
    logic [REM_W-1:0]  rem_ext;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign root_in = root_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign tag_in  = tag_q[i-1];
    end

    always_comb begin
      rem_ext = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
      trial   = {root_in, 2'b01};
      ge      = rem_ext >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[i]  <= {rad_in[IN_W-3:0], 2'b00};
      root_q[i] <= {root_in[ROOT_W-2:0], ge};
      rem_q[i]  <= ge ? rem_ext - trial : rem_ext;
      tag_q[i]  <= tag_in;
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign tag_o   = tag_q[ROOT_W-1];

endmodule

// ----- src/adm_div.sv -----
module adm_div #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 15,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [TAG_W-1:0] tag_o
);
  logic             vld_q [NUM_W];
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [TAG_W-1:0] tag_q [NUM_W];

  // restoring divide, one quotient bit per stage shifted into num
  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             vld_in;
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   rem_ext;
    logic [DEN_W:0]   rem_sub;
    logic             q_bit;

    if (i == 0) begin : g_first
      assign vld_in = valid_i;
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[i-1];
      assign num_in = num_q[i-1];
      assign den_in = den_q[i-1];
      assign rem_in = rem_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    always_comb begin
      rem_ext = {rem_in, num_in[NUM_W-1]};
      rem_sub = rem_ext - {1'b0, den_in};
      q_bit   = rem_ext >= {1'b0, den_in};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[i] <= {num_in[NUM_W-2:0], q_bit};
      den_q[i] <= den_in;
      rem_q[i] <= q_bit ? rem_sub[DEN_W-1:0] : rem_ext[DEN_W-1:0];
      tag_q[i] <= tag_in;
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quot_o  = num_q[NUM_W-1];
  assign tag_o   = tag_q[NUM_W-1];

endmodule

// ----- src/adm_curve.sv -----
module adm_curve #(
  parameter int unsigned TAG_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [16:0]      r_i,
  input  logic [15:0]      exp_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [16:0]      s_o,
  output logic [TAG_W-1:0] tag_o
);
  import adm_pkg::*;

  localparam logic [30:0] ACC_ONE  = 31'h4000_0000;
  localparam logic [20:0] LOG_BASE = 21'h10_0000;

  // ---- normalize: leading one and Q1.30 mantissa
  logic [4:0]  lead;
  logic [30:0] m0;

  always_comb begin
    lead = '0;
    for (int b = 1; b <= 16; b++) begin
      if (r_i[b]) begin
        lead = 5'(b);
      end
    end
    m0 = 31'(r_i) << (5'd30 - lead);
  end

  logic             vld_c0_q;
  logic [16:0]      r_c0_q;
  logic [4:0]       k_c0_q;
  logic [30:0]      m_c0_q;
  logic [TAG_W-1:0] tag_c0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c0_q <= 1'b0;
    end else begin
      vld_c0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_c0_q   <= r_i;
    k_c0_q   <= lead;
    m_c0_q   <= m0;
    tag_c0_q <= tag_i;
  end

  // ---- log2 fraction: one squaring per stage
  logic             lvld_q [EXP_STEPS];
  logic [16:0]      lr_q   [EXP_STEPS];
  logic [4:0]       lk_q   [EXP_STEPS];
  logic [30:0]      lm_q   [EXP_STEPS];
  logic [15:0]      lf_q   [EXP_STEPS];
  logic [TAG_W-1:0] ltag_q [EXP_STEPS];

  for (genvar j = 0; j < EXP_STEPS; j++) begin : g_log
    logic             vld_in;
    logic [16:0]      r_in;
    logic [4:0]       k_in;
    logic [30:0]      m_in;
    logic [15:0]      f_in;
    logic [TAG_W-1:0] tag_in;
    logic [61:0]      sq;
    logic [31:0]      sh;

    if (j == 0) begin : g_first
      assign vld_in = vld_c0_q;
      assign r_in   = r_c0_q;
      assign k_in   = k_c0_q;
      assign m_in   = m_c0_q;
      assign f_in   = '0;
      assign tag_in = tag_c0_q;
    end else begin : g_next
      assign vld_in = lvld_q[j-1];
      assign r_in   = lr_q[j-1];
      assign k_in   = lk_q[j-1];
      assign m_in   = lm_q[j-1];
      assign f_in   = lf_q[j-1];
      assign tag_in = ltag_q[j-1];
    end

    always_comb begin
      sq = m_in * m_in;
      sh = sq[61:30];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lvld_q[j] <= 1'b0;
      end else begin
        lvld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      lr_q[j]   <= r_in;
      lk_q[j]   <= k_in;
      lm_q[j]   <= sh[31] ? sh[31:1] : sh[30:0];
      lf_q[j]   <= {f_in[14:0], sh[31]};
      ltag_q[j] <= tag_in;
    end
  end

  // ---- t = p * (-log2 r) in Q.16
  logic [20:0] neg_log;
  logic [36:0] t_prod;

  always_comb begin
    neg_log = LOG_BASE - {lk_q[EXP_STEPS-1], lf_q[EXP_STEPS-1]};
    t_prod  = exp_i * neg_log;
  end

  logic             vld_c1_q;
  logic [16:0]      r_c1_q;
  logic [24:0]      t_c1_q;
  logic [TAG_W-1:0] tag_c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c1_q <= 1'b0;
    end else begin
      vld_c1_q <= lvld_q[EXP_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    r_c1_q   <= lr_q[EXP_STEPS-1];
    t_c1_q   <= t_prod[36:12];
    tag_c1_q <= ltag_q[EXP_STEPS-1];
  end

  // ---- 2^-frac: one factor per fraction bit, MSB first
  logic             evld_q [EXP_STEPS];
  logic [16:0]      er_q   [EXP_STEPS];
  logic [24:0]      et_q   [EXP_STEPS];
  logic [30:0]      eacc_q [EXP_STEPS];
  logic [TAG_W-1:0] etag_q [EXP_STEPS];

  for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
    logic             vld_in;
    logic [16:0]      r_in;
    logic [24:0]      t_in;
    logic [30:0]      acc_in;
    logic [TAG_W-1:0] tag_in;
    logic [60:0]      prod;

    if (j == 0) begin : g_first
      assign vld_in = vld_c1_q;
      assign r_in   = r_c1_q;
      assign t_in   = t_c1_q;
      assign acc_in = ACC_ONE;
      assign tag_in = tag_c1_q;
    end else begin : g_next
      assign vld_in = evld_q[j-1];
      assign r_in   = er_q[j-1];
      assign t_in   = et_q[j-1];
      assign acc_in = eacc_q[j-1];
      assign tag_in = etag_q[j-1];
    end

    always_comb begin
      prod = acc_in * EXP_FACTOR[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        evld_q[j] <= 1'b0;
      end else begin
        evld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      er_q[j]   <= r_in;
      et_q[j]   <= t_in;
      eacc_q[j] <= t_in[EXP_STEPS-1-j] ? prod[60:30] : acc_in;
      etag_q[j] <= tag_in;
    end
  end

  // ---- integer part of t as a right shift
  logic             vld_c2_q;
  logic [16:0]      r_c2_q;
  logic [30:0]      acc_c2_q;
  logic [TAG_W-1:0] tag_c2_q;
  logic [8:0]       ip;

  assign ip = et_q[EXP_STEPS-1][24:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c2_q <= 1'b0;
    end else begin
      vld_c2_q <= evld_q[EXP_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    r_c2_q   <= er_q[EXP_STEPS-1];
    acc_c2_q <= (ip >= 9'(EXP_IP_LIMIT)) ? '0 : eacc_q[EXP_STEPS-1] >> ip[4:0];
    tag_c2_q <= etag_q[EXP_STEPS-1];
  end

  // ---- s = r * 2^-t
  logic [47:0]      s_prod;
  logic             vld_c3_q;
  logic [16:0]      s_c3_q;
  logic [TAG_W-1:0] tag_c3_q;

  assign s_prod = r_c2_q * acc_c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c3_q <= 1'b0;
    end else begin
      vld_c3_q <= vld_c2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_c3_q   <= s_prod[46:30];
    tag_c3_q <= tag_c2_q;
  end

  assign valid_o = vld_c3_q;
  assign s_o     = s_c3_q;
  assign tag_o   = tag_c3_q;

endmodule

// ----- src/arcade_drive_mixer.sv -----
// Arcade drive mixer: joystick sample in, left/right motor power out.
//
// Sample channel: a transfer happens on a clock edge with start_i high and
// busy_o low. busy_o is always low, so a new sample may be given every cycle.
// Result channel: done_o is high for exactly one cycle with left_power_o and
// right_power_o; the receiver takes it on that edge and cannot hold it off.
// From the start transfer to done_o a sample passes the bit-serial
// pipelines: 24-stage square root, dead-zone divide (33), curve unit (36),
// normalize divide (41), plus eight single stages (capture, radius scale,
// dead-zone test, axis magnitude, axis scale, mix, normalize setup, output).
// Divides by the full scale are reciprocal multiplies.
// Throughput is one sample per cycle; results come out in order.
// Config channel: cfg_valid_i/cfg_ready_o, cfg_ready_o always high. Index 0
// reverse, 1 dead zone (Q0.16), 2 curve exponent (Q4.12). Write only while no
// sample is in flight; the pipeline reads the live registers.
// Reset (rst_ni low, async) empties the pipeline and loads reverse=0,
// dead zone=1311, exponent=2048.
module arcade_drive_mixer #(
  parameter int unsigned AXIS_FULL_SCALE = 127
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [7:0]  turn_axis_i,
  input  logic signed [7:0]  forward_axis_i,
  output logic               done_o,
  output logic signed [14:0] left_power_o,
  output logic signed [14:0] right_power_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import adm_pkg::*;

  // divide by full scale as a reciprocal multiply, exact for numerators below 2^24
  localparam int unsigned DIV_SHIFT = 24 + $clog2(AXIS_FULL_SCALE);
  localparam logic [24:0] DIV_RECIP =
    25'(((64'd1 << DIV_SHIFT) + 64'(AXIS_FULL_SCALE) - 64'd1) / 64'(AXIS_FULL_SCALE));

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------- config registers
  logic        rev_q;
  logic [14:0] dz_q;
  logic [15:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q <= 1'b0;
      dz_q  <= 15'd1311;
      p_q   <= 16'd2048;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_REVERSE:   rev_q <= cfg_data_i[0];
        CFG_DEAD_ZONE: dz_q  <= cfg_data_i[14:0];
        CFG_CURVE:     p_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- T0: capture sample, sum of squares
  logic signed [15:0] sq_x;
  logic signed [15:0] sq_y;
  logic        [16:0] sq_sum;

  always_comb begin
    sq_x   = turn_axis_i * turn_axis_i;
    sq_y   = forward_axis_i * forward_axis_i;
    sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
  end

  logic        vld_t0_q;
  logic [15:0] xy_t0_q;
  logic [15:0] sum_t0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_t0_q <= 1'b0;
    end else begin
      vld_t0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    xy_t0_q  <= {turn_axis_i, forward_axis_i};
    sum_t0_q <= sq_sum[15:0];
  end

  // ---------------- radius: isqrt(sum << 32) / full scale
  logic        sqrt_vld;
  logic [23:0] sqrt_root;
  logic [15:0] sqrt_tag;

  adm_sqrt #(.IN_W(48), .TAG_W(16)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_t0_q),
    .rad_i   ({sum_t0_q, 32'd0}),
    .tag_i   (xy_t0_q),
    .valid_o (sqrt_vld),
    .root_o  (sqrt_root),
    .tag_o   (sqrt_tag)
  );

  logic [48:0] rad_prod;

  assign rad_prod = 49'(sqrt_root) * 49'(DIV_RECIP);

  logic        rad_vld_q;
  logic [23:0] rad_q;
  logic [15:0] rad_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_vld_q <= 1'b0;
    end else begin
      rad_vld_q <= sqrt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q     <= 24'(rad_prod >> DIV_SHIFT);
    rad_tag_q <= sqrt_tag;
  end

  // ---------------- T1: saturate d, dead-zone test, rescale operands
  logic [16:0] d_sat;
  logic [16:0] d_off;
  logic        in_dz;

  always_comb begin
    d_sat = (rad_q > 24'd131071) ? 17'd131071 : rad_q[16:0];
    in_dz = d_sat <= {2'b00, dz_q};
    d_off = d_sat - {2'b00, dz_q};
  end

  logic        vld_t1_q;
  logic [32:0] num_t1_q;
  logic [16:0] den_t1_q;
  logic [16:0] tag_t1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_t1_q <= 1'b0;
    end else begin
      vld_t1_q <= rad_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_t1_q <= {d_off, 16'd0};
    den_t1_q <= 17'(Q16_ONE) - {2'b00, dz_q};
    tag_t1_q <= {in_dz, rad_tag_q};
  end

  logic        r_vld;
  logic [32:0] r_quot;
  logic [16:0] r_tag;

  adm_div #(.NUM_W(33), .DEN_W(17), .TAG_W(17)) u_div_dz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_t1_q),
    .num_i   (num_t1_q),
    .den_i   (den_t1_q),
    .tag_i   (tag_t1_q),
    .valid_o (r_vld),
    .quot_o  (r_quot),
    .tag_o   (r_tag)
  );

  // ---------------- response curve s = r^(1+p)
  logic [16:0] r_cap;

  assign r_cap = (r_quot > 33'(Q16_ONE)) ? 17'(Q16_ONE) : r_quot[16:0];

  logic        crv_vld;
  logic [16:0] crv_s;
  logic [16:0] crv_tag;

  adm_curve #(.TAG_W(17)) u_curve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_vld),
    .r_i     (r_cap),
    .exp_i   (p_q),
    .tag_i   (r_tag),
    .valid_o (crv_vld),
    .s_o     (crv_s),
    .tag_o   (crv_tag)
  );

  // ---------------- T2: magnitudes |axis| * s, dead zone forces s to zero
  // |axis| reaches 128 for a -128 input, so all nine bits are kept
  logic        [16:0] s_eff;
  logic signed [8:0]  x_ext;
  logic signed [8:0]  y_ext;
  logic        [8:0]  ax;
  logic        [8:0]  ay;

  always_comb begin
    s_eff = crv_tag[16] ? 17'd0 : crv_s;
    x_ext = {crv_tag[15], crv_tag[15:8]};
    y_ext = {crv_tag[7], crv_tag[7:0]};
    if (rev_q) begin
      y_ext = -y_ext;
    end
    ax = x_ext[8] ? -x_ext : x_ext;
    ay = y_ext[8] ? -y_ext : y_ext;
  end

  logic        vld_t2_q;
  logic [23:0] nx_t2_q;
  logic [23:0] ny_t2_q;
  logic        sx_t2_q;
  logic        sy_t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_t2_q <= 1'b0;
    end else begin
      vld_t2_q <= crv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_t2_q <= 24'(ax) * 24'(s_eff);
    ny_t2_q <= 24'(ay) * 24'(s_eff);
    sx_t2_q <= x_ext[8];
    sy_t2_q <= y_ext[8];
  end

  // ---------------- axis scale: magnitude / full scale
  logic [48:0] fx_prod;
  logic [48:0] fy_prod;

  always_comb begin
    fx_prod = 49'(nx_t2_q) * 49'(DIV_RECIP);
    fy_prod = 49'(ny_t2_q) * 49'(DIV_RECIP);
  end

  logic        fxy_vld_q;
  logic [23:0] fx_mag_q;
  logic [23:0] fy_mag_q;
  logic        fx_sign_q;
  logic        fy_sign_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fxy_vld_q <= 1'b0;
    end else begin
      fxy_vld_q <= vld_t2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_mag_q  <= 24'(fx_prod >> DIV_SHIFT);
    fy_mag_q  <= 24'(fy_prod >> DIV_SHIFT);
    fx_sign_q <= sx_t2_q;
    fy_sign_q <= sy_t2_q;
  end

  // ---------------- T3: mix left = fwd + turn, right = fwd - turn
  logic [24:0] fx_s;
  logic [24:0] fy_s;

  always_comb begin
    fx_s = fx_sign_q ? -{1'b0, fx_mag_q} : {1'b0, fx_mag_q};
    fy_s = fy_sign_q ? -{1'b0, fy_mag_q} : {1'b0, fy_mag_q};
  end

  logic        vld_t3_q;
  logic [25:0] lp_t3_q;
  logic [25:0] rp_t3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_t3_q <= 1'b0;
    end else begin
      vld_t3_q <= fxy_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lp_t3_q <= {fy_s[24], fy_s} + {fx_s[24], fx_s};
    rp_t3_q <= {fy_s[24], fy_s} - {fx_s[24], fx_s};
  end

  // ---------------- T4: normalize operands; small values pass through /1
  logic [25:0] al;
  logic [25:0] ar;
  logic [24:0] mx;
  logic        big;

  always_comb begin
    al  = lp_t3_q[25] ? -lp_t3_q : lp_t3_q;
    ar  = rp_t3_q[25] ? -rp_t3_q : rp_t3_q;
    mx  = (al[24:0] > ar[24:0]) ? al[24:0] : ar[24:0];
    big = mx > 25'(Q16_ONE);
  end

  logic        vld_t4_q;
  logic [40:0] nl_t4_q;
  logic [40:0] nr_t4_q;
  logic [24:0] den_t4_q;
  logic        sl_t4_q;
  logic        sr_t4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_t4_q <= 1'b0;
    end else begin
      vld_t4_q <= vld_t3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nl_t4_q  <= big ? {al[24:0], 16'd0} : 41'(al[24:0]);
    nr_t4_q  <= big ? {ar[24:0], 16'd0} : 41'(ar[24:0]);
    den_t4_q <= big ? mx : 25'd1;
    sl_t4_q  <= lp_t3_q[25];
    sr_t4_q  <= rp_t3_q[25];
  end

  logic        nl_vld;
  logic        nr_vld;
  logic [40:0] nl_mag;
  logic [40:0] nr_mag;
  logic        nl_sign;
  logic        nr_sign;

  adm_div #(.NUM_W(41), .DEN_W(25), .TAG_W(1)) u_div_nl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_t4_q),
    .num_i   (nl_t4_q),
    .den_i   (den_t4_q),
    .tag_i   (sl_t4_q),
    .valid_o (nl_vld),
    .quot_o  (nl_mag),
    .tag_o   (nl_sign)
  );

  adm_div #(.NUM_W(41), .DEN_W(25), .TAG_W(1)) u_div_nr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_t4_q),
    .num_i   (nr_t4_q),
    .den_i   (den_t4_q),
    .tag_i   (sr_t4_q),
    .valid_o (nr_vld),
    .quot_o  (nr_mag),
    .tag_o   (nr_sign)
  );

  // ---------------- T5: scale to hundredths of a percent, saturate, sign
  // magnitudes are at most one (Q16) here
  logic [30:0] pl_prod;
  logic [30:0] pr_prod;
  logic [14:0] pl_mag;
  logic [14:0] pr_mag;

  always_comb begin
    pl_prod = 31'(nl_mag[16:0]) * 31'(POWER_LIMIT);
    pr_prod = 31'(nr_mag[16:0]) * 31'(POWER_LIMIT);
    pl_mag  = (pl_prod[30:16] > 15'(POWER_LIMIT)) ? 15'(POWER_LIMIT) : pl_prod[30:16];
    pr_mag  = (pr_prod[30:16] > 15'(POWER_LIMIT)) ? 15'(POWER_LIMIT) : pr_prod[30:16];
  end

  logic        done_q;
  logic [14:0] left_q;
  logic [14:0] right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= nl_vld & nr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= nl_sign ? -pl_mag : pl_mag;
    right_q <= nr_sign ? -pr_mag : pr_mag;
  end

  assign done_o        = done_q;
  assign left_power_o  = left_q;
  assign right_power_o = right_q;

endmodule

// ----- tb/arcade_drive_mixer_tb.sv -----
`timescale 1ns / 1ps

module arcade_drive_mixer_tb;
  import adm_pkg::*;

  // Pipeline depth, plus margin for the drain wait.
  localparam int unsigned PIPE_LATENCY  = 142;
  localparam int unsigned DRAIN_CYCLES  = PIPE_LATENCY + 20;
  // Watchdog limit on consecutive cycles with neither a transfer nor a result.
  localparam int unsigned WATCHDOG_MAX  = 8 * (PIPE_LATENCY + 10);
  localparam int          AXIS_FS       = 127;
  localparam int          N_RANDOM      = 750;

  typedef struct packed {
    logic signed [7:0] turn;
    logic signed [7:0] fwd;
  } stick_t;

  typedef struct packed {
    logic signed [14:0] left;
    logic signed [14:0] right;
  } power_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [7:0]  turn_axis_i;
  logic signed [7:0]  forward_axis_i;
  logic               done_o;
  logic signed [14:0] left_power_o;
  logic signed [14:0] right_power_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;

  arcade_drive_mixer #(.AXIS_FULL_SCALE(AXIS_FS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .turn_axis_i    (turn_axis_i),
    .forward_axis_i (forward_axis_i),
    .done_o         (done_o),
    .left_power_o   (left_power_o),
    .right_power_o  (right_power_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Local copy of the mixer registers, written in step with the DUT.
  logic        mix_reverse;
  logic [14:0] mix_dead_zone;
  logic [15:0] mix_curve;

  stick_t samples_pending[$];
  power_t powers_expected[$];
  int     errors = 0;
  int     mismatch_cnt = 0;
  int     idle_cycles = 0;

  // ---------------------------------------------------------------- math
  function automatic longint unsigned root64(longint unsigned n_in);
    longint unsigned n, res, b;
    n = n_in;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // -log2(r/1.0) in Q.16, r in Q1.16 (1..65536)
  function automatic longint unsigned neglog2_q16(longint unsigned r);
    int unsigned     k;
    longint unsigned m, f;
    k = 0;
    f = 0;
    while (k < 16 && (r >> (k + 1)) != 0) k++;
    m = r << (30 - k);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      f <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        f |= 1;
      end
    end
    return (64'd16 << 16) - ((longint'(k) << 16) + f);
  endfunction

  // 2^-t in Q0.30, t in Q.16
  function automatic longint unsigned pow2_neg_q30(longint unsigned t);
    longint unsigned ip, acc, v;
    ip = t >> 16;
    acc = 64'd1 << 30;
    v = root64(64'd1 << 59);
    if (ip >= EXP_IP_LIMIT) return 0;
    for (int b = 15; b >= 0; b--) begin
      if ((t >> b) & 1) acc = (acc * v) >> 30;
      v = root64(v << 30);
    end
    return acc >> ip;
  endfunction

  function automatic longint clamp_power(longint v);
    if (v > longint'(POWER_LIMIT)) return longint'(POWER_LIMIT);
    if (v < -longint'(POWER_LIMIT)) return -longint'(POWER_LIMIT);
    return v;
  endfunction

  function automatic power_t mix_power(stick_t st);
    longint          x, y, fx, fy, lp, rp, al, ar, mx;
    longint unsigned radius, r, s, dz, t;
    power_t          res;
    x = st.turn;
    y = st.fwd;
    dz = mix_dead_zone;
    radius = root64(longint'(x * x + y * y) << 32) / AXIS_FS;
    if (radius > 131071) radius = 131071;
    if (radius <= dz) begin
      res.left = '0;
      res.right = '0;
      return res;
    end
    r = ((radius - dz) * Q16_ONE) / (Q16_ONE - dz);
    if (r > Q16_ONE) r = Q16_ONE;
    t = (longint'(mix_curve) * neglog2_q16(r)) >> 12;
    s = (r * pow2_neg_q30(t)) >> 30;
    if (mix_reverse) y = -y;
    fx = (x * longint'(s)) / AXIS_FS;
    fy = (y * longint'(s)) / AXIS_FS;
    lp = fy + fx;
    rp = fy - fx;
    al = lp < 0 ? -lp : lp;
    ar = rp < 0 ? -rp : rp;
    mx = al > ar ? al : ar;
    if (mx > longint'(Q16_ONE)) begin
      lp = (lp * longint'(Q16_ONE)) / mx;
      rp = (rp * longint'(Q16_ONE)) / mx;
    end
    lp = clamp_power((lp * longint'(POWER_LIMIT)) / longint'(Q16_ONE));
    rp = clamp_power((rp * longint'(POWER_LIMIT)) / longint'(Q16_ONE));
    res.left = lp[14:0];
    res.right = rp[14:0];
    return res;
  endfunction

  // ------------------------------------------------------------ driver
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i        <= 1'b0;
      turn_axis_i    <= '0;
      forward_axis_i <= '0;
      gap_left       <= 0;
    end else begin
      // A transfer happens at this edge if start was up and busy low.
      if (start_i && !busy_o) begin
        powers_expected.push_back(mix_power(samples_pending.pop_front()));
      end
      if (start_i && busy_o) begin
        // hold the item until taken
      end else if (gap_left > 0) begin
        start_i  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (samples_pending.size() > 0) begin
        // Next item: head after any pop above. Draw the gap before the one after it.
        start_i        <= 1'b1;
        turn_axis_i    <= samples_pending[0].turn;
        forward_axis_i <= samples_pending[0].fwd;
        gap_left       <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done_o) begin
        if (powers_expected.size() == 0) begin
          errors++;
          if (mismatch_cnt < 10)
            $display("unexpected result: left %0d right %0d", left_power_o, right_power_o);
          mismatch_cnt++;
        end else begin
          power_t want;
          want = powers_expected.pop_front();
          if (want.left !== left_power_o || want.right !== right_power_o) begin
            errors++;
            if (mismatch_cnt < 10)
              $display("power mismatch: exp L %0d R %0d, got L %0d R %0d",
                       want.left, want.right, left_power_o, right_power_o);
            mismatch_cnt++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ------------------------------------------------------ stimulus flow
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_REVERSE:   mix_reverse   = val[0];
      CFG_DEAD_ZONE: mix_dead_zone = val[14:0];
      CFG_CURVE:     mix_curve     = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for the pipeline to empty; no sample may be in flight at a write.
  task automatic drain();
    wait (samples_pending.size() == 0 && !start_i);
    wait (powers_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [7:0] rnd_axis();
    case ($urandom_range(0, 9))
      0:       return 8'sd127;
      1:       return -8'sd127;
      2:       return -8'sd128;
      3:       return 8'sd0;
      4:       return 8'($urandom_range(0, 12) - 6);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_sample(logic signed [7:0] tx, logic signed [7:0] fy);
    stick_t st;
    st.turn = tx;
    st.fwd  = fy;
    samples_pending.push_back(st);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) push_sample(rnd_axis(), rnd_axis());
    drain();
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    mix_reverse    = 1'b0;
    mix_dead_zone  = 15'd1311;
    mix_curve      = 16'd2048;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, dead zone, -128 axis, diagonals, reset config.
    push_sample(8'sd0, 8'sd0);
    push_sample(8'sd1, 8'sd1);
    push_sample(8'sd127, 8'sd0);
    push_sample(-8'sd127, 8'sd0);
    push_sample(8'sd0, 8'sd127);
    push_sample(8'sd0, -8'sd127);
    push_sample(8'sd127, 8'sd127);
    push_sample(-8'sd127, -8'sd127);
    push_sample(-8'sd128, -8'sd128);
    push_sample(-8'sd128, 8'sd127);
    push_sample(8'sd64, -8'sd32);
    push_sample(8'sd2, 8'sd2);
    drain();

    // Reverse, max dead zone, zero curve.
    write_reg(CFG_REVERSE, 16'hFFFF);
    write_reg(CFG_DEAD_ZONE, 16'hFFFF);
    write_reg(CFG_CURVE, 16'd0);
    push_sample(8'sd127, 8'sd127);
    push_sample(-8'sd128, 8'sd0);
    push_sample(8'sd0, 8'sd100);
    push_sample(8'sd50, -8'sd127);
    drain();

    // Huge exponent: integer shift of 31 or more gives zero power.
    write_reg(CFG_DEAD_ZONE, 16'd0);
    write_reg(CFG_CURVE, 16'hFFFF);
    push_sample(8'sd3, 8'sd3);
    push_sample(8'sd127, 8'sd127);
    push_sample(8'sd10, -8'sd5);
    drain();
    random_phase(150);

    write_reg(CFG_REVERSE, 16'd0);
    write_reg(CFG_CURVE, 16'd4096);
    write_reg(CFG_DEAD_ZONE, 16'd1311);
    random_phase(150);

    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_REVERSE, 16'($urandom_range(0, 1)));
      write_reg(CFG_DEAD_ZONE, 16'($urandom_range(0, 32767)));
      write_reg(CFG_CURVE, ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
                                                      : 16'($urandom_range(0, 16384)));
      random_phase(150);
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
